/* hw/rtl/aksp_pkg.sv */
// Package: shared constants, types and helpers for the key sequence parser.
`default_nettype none
package aksp_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned PhaseW = 3;

  typedef logic [ByteW-1:0]  byte_t;
  typedef logic [PhaseW-1:0] phase_t;

  // Parser phases; codes 6 and 7 behave as idle.
  localparam phase_t PH_IDLE    = 3'd0;
  localparam phase_t PH_ESC     = 3'd1;
  localparam phase_t PH_BRACKET = 3'd2;
  localparam phase_t PH_NUM1    = 3'd3;
  localparam phase_t PH_SEMI    = 3'd4;
  localparam phase_t PH_NUM2    = 3'd5;

  // Special key codes
  localparam byte_t KEY_UNKNOWN = 8'd0;
  localparam byte_t KEY_UP      = 8'd1;
  localparam byte_t KEY_DOWN    = 8'd2;
  localparam byte_t KEY_RIGHT   = 8'd3;
  localparam byte_t KEY_LEFT    = 8'd4;
  localparam byte_t KEY_CLEAR   = 8'd5;

  // Character codes
  localparam byte_t CH_ESC     = 8'd27;
  localparam byte_t CH_BRACKET = 8'h5B;
  localparam byte_t CH_SEMI    = 8'h3B;
  localparam byte_t CH_0       = 8'h30;
  localparam byte_t CH_9       = 8'h39;
  localparam byte_t CH_A       = 8'h41;
  localparam byte_t CH_B       = 8'h42;
  localparam byte_t CH_C       = 8'h43;
  localparam byte_t CH_D       = 8'h44;
  localparam byte_t CH_J       = 8'h4A;
  localparam byte_t CLEAR_ARG  = 8'd2;

  typedef struct packed {
    byte_t key_value;
    byte_t first_number;
    byte_t second_number;
    logic  is_special;
  } key_res_t;

  typedef struct packed {
    phase_t   phase;
    byte_t    first_acc;
    byte_t    second_acc;
    logic     emit;
    key_res_t res;
  } step_t;

  // acc * 10 + digit, wrapping at 256
  function automatic byte_t add_digit(input byte_t acc, input byte_t ch);
    byte_t d;
    d = ch - CH_0;
    return byte_t'({acc[4:0], 3'b000} + {acc[6:0], 1'b0} + d);
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/aksp_if.sv */
// Interfaces: byte input channel and key result channel.
`default_nettype none
interface aksp_byte_if;
  logic               valid;
  logic               ready;
  aksp_pkg::byte_t    rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface aksp_key_if;
  logic               valid;
  logic               ready;
  logic               is_special;
  aksp_pkg::byte_t    key_value;
  aksp_pkg::byte_t    first_number;
  aksp_pkg::byte_t    second_number;

  modport source (output valid, output is_special, output key_value,
                  output first_number, output second_number, input ready);
  modport sink   (input valid, input is_special, input key_value,
                  input first_number, input second_number, output ready);
endinterface
`default_nettype wire

/* hw/rtl/ansi_key_sequence_parser.sv */
// Top level: terminal byte stream to key result stream.
//
//   channel  dir  payload                                         transfer when
//   in_key   in   rx_byte                                         valid & ready
//   out_key  out  is_special, key_value, first/second_number      valid & ready
//
// One byte per cycle sustained while the output is not stalled: input register, one parser step, result register.
// A transferred byte waits in the input register until the step advances; its key result is then registered.
// Reset clears the phase, both accumulators and both valid flags.
// An output stall holds the input register, the parser state and the result register; the input register is refilled as
// soon as it drains.
`default_nettype none
module ansi_key_sequence_parser (
  input  wire       clk,
  input  wire       rst_n,
  aksp_byte_if.sink in_key,
  aksp_key_if.source out_key
);

  logic              in_vld_r;
  aksp_pkg::byte_t   in_byte_r;
  aksp_pkg::phase_t  phase_r;
  aksp_pkg::byte_t   first_r;
  aksp_pkg::byte_t   second_r;
  logic              out_vld_r;
  aksp_pkg::key_res_t out_res_r;
  aksp_pkg::step_t   step;
  logic              adv;

  assign adv          = in_vld_r && (!out_vld_r || out_key.ready);
  assign in_key.ready = !in_vld_r || adv;

  aksp_step u_step (
    .phase      (phase_r),
    .first_acc  (first_r),
    .second_acc (second_r),
    .rx_byte    (in_byte_r),
    .step       (step)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      phase_r   <= aksp_pkg::PH_IDLE;
      first_r   <= '0;
      second_r  <= '0;
    end else begin
      if (in_key.ready) begin
        in_vld_r <= in_key.valid;
      end
      if (adv) begin
        phase_r  <= step.phase;
        first_r  <= step.first_acc;
        second_r <= step.second_acc;
      end
      if (adv) begin
        out_vld_r <= step.emit;
      end else if (out_key.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_key.ready && in_key.valid) begin
      in_byte_r <= in_key.rx_byte;
    end
    if (adv && step.emit) begin
      out_res_r <= step.res;
    end
  end

  assign out_key.valid         = out_vld_r;
  assign out_key.is_special    = out_res_r.is_special;
  assign out_key.key_value     = out_res_r.key_value;
  assign out_key.first_number  = out_res_r.first_number;
  assign out_key.second_number = out_res_r.second_number;

endmodule
`default_nettype wire

/* hw/rtl/aksp_step.sv */
// Per-byte parser step: next phase, accumulators and optional key result.
`default_nettype none
module aksp_step (
  input  wire aksp_pkg::phase_t phase,
  input  wire aksp_pkg::byte_t  first_acc,
  input  wire aksp_pkg::byte_t  second_acc,
  input  wire aksp_pkg::byte_t  rx_byte,
  output aksp_pkg::step_t       step
);

  logic            is_dec;
  aksp_pkg::byte_t final_code;

  always_comb begin
    is_dec = rx_byte inside {[aksp_pkg::CH_0:aksp_pkg::CH_9]};
  end

  always_comb begin
    case (rx_byte)
      aksp_pkg::CH_A: final_code = aksp_pkg::KEY_UP;
      aksp_pkg::CH_B: final_code = aksp_pkg::KEY_DOWN;
      aksp_pkg::CH_C: final_code = aksp_pkg::KEY_RIGHT;
      aksp_pkg::CH_D: final_code = aksp_pkg::KEY_LEFT;
      aksp_pkg::CH_J: begin
        final_code = (first_acc == aksp_pkg::CLEAR_ARG) ? aksp_pkg::KEY_CLEAR
                                                         : aksp_pkg::KEY_UNKNOWN;
      end
      default:        final_code = aksp_pkg::KEY_UNKNOWN;
    endcase
  end

  always_comb begin
    step                   = '0;
    step.phase             = phase;
    step.first_acc         = first_acc;
    step.second_acc        = second_acc;
    step.res.is_special    = 1'b1;
    step.res.key_value     = aksp_pkg::KEY_UNKNOWN;
    step.res.first_number  = first_acc;
    step.res.second_number = second_acc;
    case (phase)
      aksp_pkg::PH_ESC: begin
        if (rx_byte == aksp_pkg::CH_BRACKET) begin
          step.phase = aksp_pkg::PH_BRACKET;
        end else begin
          step.emit = 1'b1;
        end
      end
      aksp_pkg::PH_BRACKET: begin
        if (is_dec) begin
          step.first_acc = aksp_pkg::add_digit('0, rx_byte);
          step.phase     = aksp_pkg::PH_NUM1;
        end else begin
          step.emit          = 1'b1;
          step.res.key_value = final_code;
        end
      end
      aksp_pkg::PH_NUM1: begin
        if (is_dec) begin
          step.first_acc = aksp_pkg::add_digit(first_acc, rx_byte);
        end else if (rx_byte == aksp_pkg::CH_SEMI) begin
          step.phase = aksp_pkg::PH_SEMI;
        end else begin
          step.emit          = 1'b1;
          step.res.key_value = final_code;
        end
      end
      aksp_pkg::PH_SEMI: begin
        if (is_dec) begin
          step.second_acc = aksp_pkg::add_digit('0, rx_byte);
          step.phase      = aksp_pkg::PH_NUM2;
        end else begin
          step.emit = 1'b1;
        end
      end
      aksp_pkg::PH_NUM2: begin
        if (is_dec) begin
          step.second_acc = aksp_pkg::add_digit(second_acc, rx_byte);
        end else begin
          step.emit          = 1'b1;
          step.res.key_value = final_code;
        end
      end
      default: begin
        if (rx_byte == aksp_pkg::CH_ESC) begin
          step.phase      = aksp_pkg::PH_ESC;
          step.first_acc  = '0;
          step.second_acc = '0;
        end else begin
          step.emit              = 1'b1;
          step.res.is_special    = 1'b0;
          step.res.key_value     = rx_byte;
          step.res.first_number  = '0;
          step.res.second_number = '0;
        end
      end
    endcase
    if (step.emit) begin
      step.phase      = aksp_pkg::PH_IDLE;
      step.first_acc  = '0;
      step.second_acc = '0;
    end
  end

endmodule
`default_nettype wire
